### src/command_frame_parser_assert.svh
// Assertion macros for the command frame parser
`ifndef COMMAND_FRAME_PARSER_ASSERT_SVH
`define COMMAND_FRAME_PARSER_ASSERT_SVH

// check cons in the same cycle as ante
`define CFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("command_frame_parser: assertion failed");

// check cons in the cycle after ante
`define CFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("command_frame_parser: assertion failed");

`endif

### src/cfp_pkg.sv
// Shared constants and types of the command frame parser
package cfp_pkg;

	localparam int BUFFER_DEPTH = 16;
	localparam int IDX_W = $clog2(BUFFER_DEPTH);
	localparam int LEN_W = $clog2(BUFFER_DEPTH + 1);
	localparam int CMP_W = LEN_W + 1;

	localparam logic [7:0] CMD_PARAMS = 8'h50;
	localparam logic [7:0] CMD_STATUS = 8'h53;
	localparam logic [7:0] SOF_RESET = 8'd35;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK = 3'd0;
	localparam status_t ST_INCOMPLETE = 3'd1;
	localparam status_t ST_INVALID = 3'd2;
	localparam status_t ST_CHECKSUM = 3'd3;
	localparam status_t ST_NO_SOF = 3'd4;
	localparam status_t ST_FULL = 3'd5;

endpackage

### src/cfp_ram.sv
// Generic single-write, single-read RAM with registered read data
module cfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

### src/command_frame_parser.sv
// Command frame parser top level: byte buffer in RAM, start-symbol scan, P and S frames
// Append, and process of an empty buffer: result valid in the cycle after the accept.
// Process: one byte per cycle up to and including the start symbol (RAM read port
// sets the pace), then the frame: command byte, three gains for P, checksum byte.
// One item in work at a time; the next is taken once the sequencer is idle and the result register is free.
// Reset clears buffer length, stored gains, start symbol (to '#') and the sequencer.
module command_frame_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [7:0]         cfg_wr_data,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic               action,
	input  logic [7:0]         rx_byte,
	input  logic signed [31:0] setpoint_in,
	input  logic signed [31:0] plant_output_in,
	input  logic signed [31:0] control_error_in,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [2:0]         status,
	output logic signed [7:0]  gain_p,
	output logic signed [7:0]  integral_time,
	output logic signed [7:0]  derivative_time,
	output logic               report_valid,
	output logic signed [31:0] report_setpoint,
	output logic signed [31:0] report_output,
	output logic signed [31:0] report_error
);

	`include "command_frame_parser_assert.svh"

	localparam logic [1:0] FSM_IDLE = 2'd0;
	localparam logic [1:0] FSM_SCAN = 2'd1;
	localparam logic [1:0] FSM_FRAME = 2'd2;

	logic [1:0] state_q;
	logic [cfp_pkg::LEN_W-1:0] len_q;
	logic [cfp_pkg::IDX_W-1:0] ptr_q;
	logic [2:0] step_q;
	logic [7:0] sof_q;
	logic [7:0] gp_q, gi_q, gd_q;
	logic [7:0] cmd_q, sum_q, g0_q, g1_q, g2_q;
	logic signed [31:0] sp_q, po_q, ce_q;
	logic rsp_valid_q;
	cfp_pkg::status_t status_q;
	logic signed [7:0] out_gp_q, out_gi_q, out_gd_q;
	logic report_valid_q;
	logic signed [31:0] rep_sp_q, rep_po_q, rep_ce_q;

	logic rsp_free, cmd_acc, not_full, ram_we, rsp_set;
	logic [cfp_pkg::IDX_W-1:0] ram_raddr;
	logic [7:0] rdata;
	logic [cfp_pkg::CMP_W-1:0] ptr_ext, len_ext;
	logic next_in, p_room;
	logic done, done_rep, done_set;
	cfp_pkg::status_t done_st;

	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = !((state_q == FSM_IDLE) && rsp_free);
	assign cmd_acc = cmd_valid && !cmd_stall;
	assign not_full = len_q < cfp_pkg::LEN_W'(cfp_pkg::BUFFER_DEPTH);
	assign ram_we = cmd_acc && !action && not_full;
	assign ram_raddr = (state_q == FSM_IDLE) ? '0 : cfp_pkg::IDX_W'(ptr_q + 1'b1);
	assign rsp_set = (cmd_acc && (!action || (len_q == '0))) || done;

	assign ptr_ext = cfp_pkg::CMP_W'(ptr_q);
	assign len_ext = cfp_pkg::CMP_W'(len_q);
	assign next_in = (ptr_ext + cfp_pkg::CMP_W'(1)) < len_ext;
	assign p_room = (ptr_ext + cfp_pkg::CMP_W'(4)) < len_ext;

	cfp_ram #(
		.WIDTH(8),
		.DEPTH(cfp_pkg::BUFFER_DEPTH)
	) u_buf (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(len_q[cfp_pkg::IDX_W-1:0]),
		.wr_data(rx_byte),
		.rd_addr(ram_raddr),
		.rd_data(rdata)
	);

	always_comb begin
		done = 1'b0;
		done_st = cfp_pkg::ST_OK;
		done_rep = 1'b0;
		done_set = 1'b0;
		case (state_q)
			FSM_SCAN: begin
				if (rdata == sof_q) begin
					if (!next_in) begin
						done = 1'b1;
						done_st = cfp_pkg::ST_INCOMPLETE;
					end
				end else if (!next_in) begin
					done = 1'b1;
					done_st = cfp_pkg::ST_NO_SOF;
				end
			end
			FSM_FRAME: begin
				case (step_q)
					3'd1: begin
						if (rdata == cfp_pkg::CMD_PARAMS) begin
							if (!p_room) begin
								done = 1'b1;
								done_st = cfp_pkg::ST_INCOMPLETE;
							end
						end else if (rdata == cfp_pkg::CMD_STATUS) begin
							if (!next_in) begin
								done = 1'b1;
								done_st = cfp_pkg::ST_INCOMPLETE;
							end
						end else begin
							done = 1'b1;
							done_st = cfp_pkg::ST_INVALID;
						end
					end
					3'd2: begin
						if (cmd_q == cfp_pkg::CMD_STATUS) begin
							done = 1'b1;
							if (rdata == cfp_pkg::CMD_STATUS) begin
								done_rep = 1'b1;
							end else begin
								done_st = cfp_pkg::ST_CHECKSUM;
							end
						end
					end
					3'd5: begin
						done = 1'b1;
						if (sum_q == rdata) begin
							done_set = 1'b1;
						end else begin
							done_st = cfp_pkg::ST_CHECKSUM;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			len_q <= '0;
			ptr_q <= '0;
			step_q <= '0;
			sof_q <= cfp_pkg::SOF_RESET;
			gp_q <= '0;
			gi_q <= '0;
			gd_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				sof_q <= cfg_wr_data;
			end
			if (rsp_set) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				FSM_IDLE: begin
					if (cmd_acc) begin
						if (!action) begin
							if (not_full) begin
								len_q <= cfp_pkg::LEN_W'(len_q + 1'b1);
							end
						end else if (len_q != '0) begin
							state_q <= FSM_SCAN;
							ptr_q <= '0;
						end
					end
				end
				FSM_SCAN: begin
					if (done) begin
						state_q <= FSM_IDLE;
					end else begin
						ptr_q <= cfp_pkg::IDX_W'(ptr_q + 1'b1);
						if (rdata == sof_q) begin
							state_q <= FSM_FRAME;
							step_q <= 3'd1;
						end
					end
				end
				FSM_FRAME: begin
					if (done) begin
						state_q <= FSM_IDLE;
						if (done_st == cfp_pkg::ST_OK) begin
							len_q <= '0;
						end
						if (done_set) begin
							gp_q <= g0_q;
							gi_q <= g1_q;
							gd_q <= g2_q;
						end
					end else begin
						ptr_q <= cfp_pkg::IDX_W'(ptr_q + 1'b1);
						step_q <= 3'(step_q + 1'b1);
					end
				end
				default: begin
					state_q <= FSM_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			sp_q <= setpoint_in;
			po_q <= plant_output_in;
			ce_q <= control_error_in;
			status_q <= !action ? (not_full ? cfp_pkg::ST_OK : cfp_pkg::ST_FULL)
				: cfp_pkg::ST_INCOMPLETE;
			out_gp_q <= gp_q;
			out_gi_q <= gi_q;
			out_gd_q <= gd_q;
			report_valid_q <= 1'b0;
			rep_sp_q <= '0;
			rep_po_q <= '0;
			rep_ce_q <= '0;
		end
		if (state_q == FSM_FRAME) begin
			case (step_q)
				3'd1: begin
					cmd_q <= rdata;
					sum_q <= rdata;
				end
				3'd2: begin
					g0_q <= rdata;
					sum_q <= 8'(sum_q + rdata);
				end
				3'd3: begin
					g1_q <= rdata;
					sum_q <= 8'(sum_q + rdata);
				end
				3'd4: begin
					g2_q <= rdata;
					sum_q <= 8'(sum_q + rdata);
				end
				default: begin
				end
			endcase
		end
		if (done) begin
			status_q <= done_st;
			out_gp_q <= done_set ? g0_q : gp_q;
			out_gi_q <= done_set ? g1_q : gi_q;
			out_gd_q <= done_set ? g2_q : gd_q;
			report_valid_q <= done_rep;
			rep_sp_q <= done_rep ? sp_q : '0;
			rep_po_q <= done_rep ? po_q : '0;
			rep_ce_q <= done_rep ? ce_q : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status = status_q;
	assign gain_p = out_gp_q;
	assign integral_time = out_gi_q;
	assign derivative_time = out_gd_q;
	assign report_valid = report_valid_q;
	assign report_setpoint = rep_sp_q;
	assign report_output = rep_po_q;
	assign report_error = rep_ce_q;

	`CFP_ASSERT_NOW(a_len_bound, clk, arst_n, 1'b1, len_q <= cfp_pkg::LEN_W'(cfp_pkg::BUFFER_DEPTH))
	`CFP_ASSERT_NOW(a_busy_no_rsp, clk, arst_n, state_q != FSM_IDLE, !rsp_valid_q)
	`CFP_ASSERT_NOW(a_report_ok, clk, arst_n, rsp_valid_q && report_valid_q, status_q == cfp_pkg::ST_OK)
	`CFP_ASSERT_NEXT(a_append_len, clk, arst_n, ram_we, len_q == cfp_pkg::LEN_W'($past(len_q) + 1'b1))

endmodule
